// ===== hw/rtl/tsle_pkg.sv =====
// ----------------------------------------------------------------------------
// tsle_pkg
// Shared types and constants of the two-species lattice exchange step: site
// codes, request kinds, register indexes, beat structs and the FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package tsle_pkg;

  localparam int BOND_W  = 11;
  localparam int UNI_W   = 16;
  localparam int RATE_W  = 17;
  localparam int COUNT_W = 11;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [1:0] site_t;

  localparam site_t SITE_EMPTY = 2'd0;
  localparam site_t SITE_ONE   = 2'd1;
  localparam site_t SITE_TWO   = 2'd2;
  localparam site_t SITE_BOTH  = 2'd3;

  localparam logic [RATE_W-1:0]  RATE_ONE  = 17'h10000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [RATE_W-1:0] Q_SQUARED_RST     = 17'd16384;
  localparam logic [RATE_W-1:0] Q_FOURTH_RST      = 17'd4096;
  localparam logic [RATE_W-1:0] Q_SQUARED_EPS_RST = 17'd12288;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_MEASURE = 2'd1,
    REQ_INIT    = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Q_SQUARED     = 2'd0,
    CFG_Q_FOURTH      = 2'd1,
    CFG_Q_SQUARED_EPS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_UPD,
    ST_MEAS,
    ST_MEAS_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BOND_W-1:0] bond;
    logic [UNI_W-1:0]  uniform;
  } in_beat_t;

  typedef struct packed {
    logic               fired;
    site_t              new_left;
    site_t              new_right;
    logic [COUNT_W-1:0] count_one;
    logic [COUNT_W-1:0] count_two;
  } out_beat_t;

  typedef struct packed {
    logic [RATE_W-1:0] q_squared;
    logic [RATE_W-1:0] q_fourth;
    logic [RATE_W-1:0] q_squared_eps;
  } rates_t;

  typedef struct packed {
    logic  fired;
    site_t new_left;
    site_t new_right;
  } move_t;

endpackage

`default_nettype wire

// ===== hw/rtl/two_species_lattice_exchange_step.sv =====
// ----------------------------------------------------------------------------
// two_species_lattice_exchange_step: an update reads the bond's site pair on accept, then
// writes any move back and loads its result; the next request waits until that result is loaded.
// A measure's length is set by the walk over site rows (two banks).
// Init sweeps the banks to the step profile: one row write per cycle. After reset the banks
// are swept the same way with in_stall high; config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module two_species_lattice_exchange_step #(
  parameter int LEFT_SITES  = 1024,
  parameter int RIGHT_SITES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tsle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsle_pkg::RATE_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tsle_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tsle_pkg::out_beat_t                out_data
);

  localparam int TOTAL = LEFT_SITES + RIGHT_SITES;
  localparam int ROWS  = (TOTAL + 1) / 2;
  localparam int RW    = $clog2(ROWS);
  localparam int XW    = RW + 2;
  localparam int CW    = ((XW > tsle_pkg::BOND_W) ? XW : tsle_pkg::BOND_W) + 1;
  localparam int CNTW  = $clog2(RIGHT_SITES + 1);
  localparam int CMW   = (CNTW > tsle_pkg::COUNT_W) ? CNTW : tsle_pkg::COUNT_W;
  localparam logic [RW-1:0] FIRST_ROW = RW'(LEFT_SITES / 2);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  // site banks: even sites and odd sites, so a bond hits one entry of each
  tsle_pkg::site_t mem_e [ROWS];
  tsle_pkg::site_t mem_o [ROWS];

  tsle_pkg::state_t    state_r, state_nxt;
  tsle_pkg::rates_t    rates_r;
  tsle_pkg::in_beat_t  item_r, item_nxt;
  tsle_pkg::out_beat_t res_r, res_nxt, out_data_r, out_nxt;
  tsle_pkg::out_beat_t upd_res, meas_res;
  tsle_pkg::move_t     move;
  tsle_pkg::site_t     rd_e_r, rd_o_r, e_wd, o_wd, upd_left, upd_right;
  logic [RW-1:0]       row_r, row_nxt, rd_row_r, e_ra, o_ra, e_wa, o_wa;
  logic [RW-1:0]       in_row_e, in_row_o, it_row_e, it_row_o;
  logic                e_we, o_we;
  logic                reply_r, reply_nxt, rd_vld_r, out_valid_r, ld_out, slot_free;
  logic [CNTW-1:0]     cnt1_r, cnt2_r, cnt1_nxt, cnt2_nxt, cnt1_sum, cnt2_sum;
  logic [CW-1:0]       in_bond_c, it_bond_c;
  logic                in_ok, in_acc;
  logic [XW-1:0]       even_idx, odd_idx;
  logic                take_e, take_o;
  logic [1:0]          inc1, inc2;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rates_r.q_squared     <= tsle_pkg::Q_SQUARED_RST;
      rates_r.q_fourth      <= tsle_pkg::Q_FOURTH_RST;
      rates_r.q_squared_eps <= tsle_pkg::Q_SQUARED_EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsle_pkg::CFG_Q_SQUARED:     rates_r.q_squared     <= cfg_wdata;
        tsle_pkg::CFG_Q_FOURTH:      rates_r.q_fourth      <= cfg_wdata;
        tsle_pkg::CFG_Q_SQUARED_EPS: rates_r.q_squared_eps <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- bond addressing ----------------
  assign in_bond_c = CW'(in_data.bond);
  assign in_ok     = (in_bond_c + CW'(1)) < CW'(TOTAL);
  assign in_row_e  = RW'((in_bond_c + CW'(1)) >> 1);
  assign in_row_o  = RW'(in_bond_c >> 1);
  assign it_bond_c = CW'(item_r.bond);
  assign it_row_e  = RW'((it_bond_c + CW'(1)) >> 1);
  assign it_row_o  = RW'(it_bond_c >> 1);

  assign in_stall  = (state_r != tsle_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // ---------------- update datapath ----------------
  assign upd_left  = item_r.bond[0] ? rd_o_r : rd_e_r;
  assign upd_right = item_r.bond[0] ? rd_e_r : rd_o_r;

  tsle_xchg u_xchg (
    .rates      (rates_r),
    .left_site  (upd_left),
    .right_site (upd_right),
    .uniform    (item_r.uniform),
    .move       (move)
  );

  always_comb begin
    upd_res           = '0;
    upd_res.fired     = move.fired;
    upd_res.new_left  = move.new_left;
    upd_res.new_right = move.new_right;
  end

  // ---------------- measure datapath ----------------
  always_comb begin
    even_idx = XW'({rd_row_r, 1'b0});
    odd_idx  = XW'({rd_row_r, 1'b1});
    take_e   = rd_vld_r && (even_idx >= XW'(LEFT_SITES));
    take_o   = rd_vld_r && (odd_idx < XW'(TOTAL));
    inc1     = {1'b0, take_e & rd_e_r[0]} + {1'b0, take_o & rd_o_r[0]};
    inc2     = {1'b0, take_e & rd_e_r[1]} + {1'b0, take_o & rd_o_r[1]};
    cnt1_sum = cnt1_r + CNTW'(inc1);
    cnt2_sum = cnt2_r + CNTW'(inc2);
    meas_res = '0;
    meas_res.count_one = (CMW'(cnt1_sum) > CMW'(tsle_pkg::COUNT_MAX)) ?
                         tsle_pkg::COUNT_MAX : tsle_pkg::COUNT_W'(cnt1_sum);
    meas_res.count_two = (CMW'(cnt2_sum) > CMW'(tsle_pkg::COUNT_MAX)) ?
                         tsle_pkg::COUNT_MAX : tsle_pkg::COUNT_W'(cnt2_sum);
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsle_pkg::ST_SWEEP;
      row_r    <= '0;
      reply_r  <= 1'b0;
      rd_vld_r <= 1'b0;
      cnt1_r   <= '0;
      cnt2_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      reply_r  <= reply_nxt;
      rd_vld_r <= (state_r == tsle_pkg::ST_MEAS);
      cnt1_r   <= cnt1_nxt;
      cnt2_r   <= cnt2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    rd_row_r <= row_r;
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    reply_nxt = reply_r;
    cnt1_nxt  = cnt1_r;
    cnt2_nxt  = cnt2_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    ld_out    = 1'b0;
    out_nxt   = res_r;
    e_we = 1'b0; o_we = 1'b0;
    e_wa = row_r; o_wa = row_r;
    e_wd = tsle_pkg::SITE_EMPTY; o_wd = tsle_pkg::SITE_EMPTY;
    e_ra = row_r; o_ra = row_r;
    unique case (state_r)
      tsle_pkg::ST_SWEEP: begin
        e_we = 1'b1;
        o_we = 1'b1;
        e_wd = (XW'({row_r, 1'b0}) < XW'(LEFT_SITES)) ?
               tsle_pkg::SITE_BOTH : tsle_pkg::SITE_EMPTY;
        o_wd = (XW'({row_r, 1'b1}) < XW'(LEFT_SITES)) ?
               tsle_pkg::SITE_BOTH : tsle_pkg::SITE_EMPTY;
        row_nxt = row_r + RW'(1);
        if (row_r == LAST_ROW) begin
          row_nxt   = '0;
          reply_nxt = 1'b0;
          res_nxt   = '0;
          // the sweep after reset owes no beat, an init request does
          state_nxt = reply_r ? tsle_pkg::ST_DONE : tsle_pkg::ST_IDLE;
        end
      end
      tsle_pkg::ST_IDLE: begin
        e_ra = in_row_e;
        o_ra = in_row_o;
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          unique case (in_data.req_type)
            tsle_pkg::REQ_UPDATE: begin
              state_nxt = in_ok ? tsle_pkg::ST_UPD : tsle_pkg::ST_DONE;
            end
            tsle_pkg::REQ_MEASURE: begin
              row_nxt   = FIRST_ROW;
              cnt1_nxt  = '0;
              cnt2_nxt  = '0;
              state_nxt = tsle_pkg::ST_MEAS;
            end
            tsle_pkg::REQ_INIT: begin
              row_nxt   = '0;
              reply_nxt = 1'b1;
              state_nxt = tsle_pkg::ST_SWEEP;
            end
            default: begin
              state_nxt = tsle_pkg::ST_DONE;
            end
          endcase
        end
      end
      tsle_pkg::ST_UPD: begin
        e_wa = it_row_e;
        o_wa = it_row_o;
        e_we = move.fired;
        o_we = move.fired;
        e_wd = item_r.bond[0] ? move.new_right : move.new_left;
        o_wd = item_r.bond[0] ? move.new_left  : move.new_right;
        res_nxt = upd_res;
        out_nxt = upd_res;
        if (slot_free) begin
          ld_out    = 1'b1;
          state_nxt = tsle_pkg::ST_IDLE;
        end else begin
          state_nxt = tsle_pkg::ST_DONE;
        end
      end
      tsle_pkg::ST_MEAS: begin
        cnt1_nxt = cnt1_sum;
        cnt2_nxt = cnt2_sum;
        row_nxt  = row_r + RW'(1);
        if (row_r == LAST_ROW) begin
          state_nxt = tsle_pkg::ST_MEAS_END;
        end
      end
      tsle_pkg::ST_MEAS_END: begin
        cnt1_nxt  = cnt1_sum;
        cnt2_nxt  = cnt2_sum;
        res_nxt   = meas_res;
        state_nxt = tsle_pkg::ST_DONE;
      end
      tsle_pkg::ST_DONE: begin
        if (slot_free) begin
          ld_out    = 1'b1;
          state_nxt = tsle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsle_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- site banks ----------------
  always_ff @(posedge clk) begin
    if (e_we) begin
      mem_e[e_wa] <= e_wd;
    end
    rd_e_r <= mem_e[e_ra];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      mem_o[o_wa] <= o_wd;
    end
    rd_o_r <= mem_o[o_ra];
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_upd_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.req_type == tsle_pkg::REQ_UPDATE) && in_ok)
      |=> (state_r == tsle_pkg::ST_UPD))
    else $error("in-range update did not move to the update cycle");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r)
      |-> $past((state_r == tsle_pkg::ST_UPD) || (state_r == tsle_pkg::ST_DONE)))
    else $error("result beat raised outside update or done");

  a_fire_changes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tsle_pkg::ST_UPD) && move.fired)
      |-> ({move.new_left, move.new_right} != {upd_left, upd_right}))
    else $error("fired transition left the pair unchanged");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (e_we || o_we)
      |-> ((state_r == tsle_pkg::ST_SWEEP) || (state_r == tsle_pkg::ST_UPD)))
    else $error("site bank written outside sweep or update");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt1_r <= CNTW'(RIGHT_SITES)) && (cnt2_r <= CNTW'(RIGHT_SITES)))
    else $error("species count past the right half size");

endmodule

`default_nettype wire

// ===== hw/rtl/tsle_xchg.sv =====
// ----------------------------------------------------------------------------
// tsle_xchg
// Exchange decision for one bond: looks up the ordered site pair, builds the
// cumulative rates in table order and picks the first one above the uniform.
// ----------------------------------------------------------------------------
`default_nettype none

module tsle_xchg (
  input  tsle_pkg::rates_t             rates,
  input  tsle_pkg::site_t              left_site,
  input  tsle_pkg::site_t              right_site,
  input  logic [tsle_pkg::UNI_W-1:0]   uniform,
  output tsle_pkg::move_t              move
);

  localparam int CUM_W = tsle_pkg::RATE_W + 2;

  logic [tsle_pkg::RATE_W-1:0] eps;
  logic [tsle_pkg::RATE_W-1:0] r0, r1, r2;
  tsle_pkg::site_t             na0, nb0, na1, nb1, na2, nb2;
  logic [1:0]                  n_moves;
  logic [CUM_W-1:0]            cum0, cum1, cum2, u_ext;

  always_comb begin
    // eps saturates at zero once q squared passes one
    eps = (rates.q_squared < tsle_pkg::RATE_ONE) ?
          (tsle_pkg::RATE_ONE - rates.q_squared) : '0;
    r0 = '0; r1 = '0; r2 = '0;
    na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_EMPTY;
    na1 = tsle_pkg::SITE_EMPTY; nb1 = tsle_pkg::SITE_EMPTY;
    na2 = tsle_pkg::SITE_EMPTY; nb2 = tsle_pkg::SITE_EMPTY;
    n_moves = 2'd0;
    unique case ({left_site, right_site})
      {tsle_pkg::SITE_ONE, tsle_pkg::SITE_EMPTY}: begin
        r0 = tsle_pkg::RATE_ONE; na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_ONE;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_ONE}: begin
        r0 = rates.q_squared; na0 = tsle_pkg::SITE_ONE; nb0 = tsle_pkg::SITE_EMPTY;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_TWO, tsle_pkg::SITE_EMPTY}: begin
        r0 = tsle_pkg::RATE_ONE; na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_TWO;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_TWO}: begin
        r0 = rates.q_squared; na0 = tsle_pkg::SITE_TWO; nb0 = tsle_pkg::SITE_EMPTY;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_EMPTY}: begin
        r0 = tsle_pkg::RATE_ONE; na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_BOTH;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_BOTH}: begin
        r0 = rates.q_fourth;      na0 = tsle_pkg::SITE_BOTH; nb0 = tsle_pkg::SITE_EMPTY;
        r1 = rates.q_squared_eps; na1 = tsle_pkg::SITE_ONE;  nb1 = tsle_pkg::SITE_TWO;
        r2 = rates.q_squared_eps; na2 = tsle_pkg::SITE_TWO;  nb2 = tsle_pkg::SITE_ONE;
        n_moves = 2'd3;
      end
      {tsle_pkg::SITE_ONE, tsle_pkg::SITE_TWO}: begin
        r0 = eps;             na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_BOTH;
        r1 = rates.q_squared; na1 = tsle_pkg::SITE_TWO;   nb1 = tsle_pkg::SITE_ONE;
        n_moves = 2'd2;
      end
      {tsle_pkg::SITE_TWO, tsle_pkg::SITE_ONE}: begin
        r0 = eps;             na0 = tsle_pkg::SITE_EMPTY; nb0 = tsle_pkg::SITE_BOTH;
        r1 = rates.q_squared; na1 = tsle_pkg::SITE_ONE;   nb1 = tsle_pkg::SITE_TWO;
        n_moves = 2'd2;
      end
      {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_ONE}: begin
        r0 = tsle_pkg::RATE_ONE; na0 = tsle_pkg::SITE_ONE; nb0 = tsle_pkg::SITE_BOTH;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_ONE, tsle_pkg::SITE_BOTH}: begin
        r0 = rates.q_squared; na0 = tsle_pkg::SITE_BOTH; nb0 = tsle_pkg::SITE_ONE;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_TWO}: begin
        r0 = tsle_pkg::RATE_ONE; na0 = tsle_pkg::SITE_TWO; nb0 = tsle_pkg::SITE_BOTH;
        n_moves = 2'd1;
      end
      {tsle_pkg::SITE_TWO, tsle_pkg::SITE_BOTH}: begin
        r0 = rates.q_squared; na0 = tsle_pkg::SITE_BOTH; nb0 = tsle_pkg::SITE_TWO;
        n_moves = 2'd1;
      end
      default: begin
        n_moves = 2'd0;
      end
    endcase
  end

  always_comb begin
    cum0  = CUM_W'(r0);
    cum1  = cum0 + CUM_W'(r1);
    cum2  = cum1 + CUM_W'(r2);
    u_ext = CUM_W'(uniform);
    move.fired     = 1'b0;
    move.new_left  = left_site;
    move.new_right = right_site;
    // first transition in table order whose running sum exceeds the uniform
    if ((n_moves >= 2'd1) && (u_ext < cum0)) begin
      move.fired = 1'b1; move.new_left = na0; move.new_right = nb0;
    end else if ((n_moves >= 2'd2) && (u_ext < cum1)) begin
      move.fired = 1'b1; move.new_left = na1; move.new_right = nb1;
    end else if ((n_moves == 2'd3) && (u_ext < cum2)) begin
      move.fired = 1'b1; move.new_left = na2; move.new_right = nb2;
    end
  end

endmodule

`default_nettype wire

// ===== bench/two_species_lattice_exchange_step_test.sv =====
// ----------------------------------------------------------------------------
// two_species_lattice_exchange_step_test
// Self-checking bench for the lattice exchange step. A directed run walks the
// exchange table pair by pair, then random requests concentrate on the bonds
// around the step front. Every beat is predicted from a local copy of the
// lattice and rates and checked field by field. Rates and both idling patterns
// change between phases, and one long receiver hold backs up the input side.
// ----------------------------------------------------------------------------
module two_species_lattice_exchange_step_test;

  localparam int LEFT_SITES  = 1024;
  localparam int RIGHT_SITES = 1024;
  localparam int TOTAL_SITES = LEFT_SITES + RIGHT_SITES;

  localparam logic [tsle_pkg::REQ_W-1:0]  REQ_UNUSED = 2'd3;
  localparam logic [tsle_pkg::RATE_W-1:0] RATE_FULL  = 17'h1FFFF;
  localparam int BOND_LAST       = 2047;
  localparam int FRONT_LO        = LEFT_SITES - 17;
  localparam int FRONT_HI        = LEFT_SITES + 15;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES     = 1100;

  typedef struct {
    tsle_pkg::in_beat_t  req;
    bit                  typed;
    tsle_pkg::out_beat_t want;
  } directed_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [tsle_pkg::CFG_IDX_W-1:0] cfg_index = tsle_pkg::CFG_Q_SQUARED;
  logic [tsle_pkg::RATE_W-1:0]    cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  tsle_pkg::in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  tsle_pkg::out_beat_t out_data;

  // local copy of the block's state
  tsle_pkg::site_t             site_model [TOTAL_SITES];
  logic [tsle_pkg::RATE_W-1:0] q2_model;
  logic [tsle_pkg::RATE_W-1:0] q4_model;
  logic [tsle_pkg::RATE_W-1:0] q2eps_model;

  tsle_pkg::out_beat_t expected_results [$];
  directed_row_t       directed_plan [$];
  int                  error_count = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  logic                rx_hold_req = 1'b0;

  two_species_lattice_exchange_step #(
    .LEFT_SITES (LEFT_SITES),
    .RIGHT_SITES(RIGHT_SITES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("two_species_lattice_exchange_step_test: done, errors");
    $finish;
  end

  function automatic void load_step_profile();
    for (int i = 0; i < TOTAL_SITES; i++) begin
      site_model[i] = (i < LEFT_SITES) ? tsle_pkg::SITE_BOTH : tsle_pkg::SITE_EMPTY;
    end
  endfunction

  // Apply one request to the local lattice and return the beat it yields.
  function automatic tsle_pkg::out_beat_t exchange_predict(input tsle_pkg::in_beat_t req);
    tsle_pkg::out_beat_t res;
    tsle_pkg::site_t     lhs;
    tsle_pkg::site_t     rhs;
    tsle_pkg::site_t     to_l [3];
    tsle_pkg::site_t     to_r [3];
    int unsigned rate [3];
    int unsigned r_one;
    int unsigned q2;
    int unsigned q4;
    int unsigned q2e;
    int unsigned eps;
    int unsigned cum;
    int unsigned ones;
    int unsigned twos;
    int          moves;
    int          pos;
    res   = '0;
    moves = 0;
    cum   = 0;
    pos   = int'(req.bond);
    r_one = 32'(tsle_pkg::RATE_ONE);
    q2    = 32'(q2_model);
    q4    = 32'(q4_model);
    q2e   = 32'(q2eps_model);
    eps   = (q2 < r_one) ? (r_one - q2) : 32'd0;
    if (req.req_type == tsle_pkg::REQ_UPDATE) begin
      if (pos + 1 >= TOTAL_SITES) return res;
      lhs = site_model[pos];
      rhs = site_model[pos + 1];
      case ({lhs, rhs})
        {tsle_pkg::SITE_ONE, tsle_pkg::SITE_EMPTY}: begin
          moves = 1; rate[0] = r_one;
          to_l[0] = tsle_pkg::SITE_EMPTY; to_r[0] = tsle_pkg::SITE_ONE;
        end
        {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_ONE}: begin
          moves = 1; rate[0] = q2;
          to_l[0] = tsle_pkg::SITE_ONE; to_r[0] = tsle_pkg::SITE_EMPTY;
        end
        {tsle_pkg::SITE_TWO, tsle_pkg::SITE_EMPTY}: begin
          moves = 1; rate[0] = r_one;
          to_l[0] = tsle_pkg::SITE_EMPTY; to_r[0] = tsle_pkg::SITE_TWO;
        end
        {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_TWO}: begin
          moves = 1; rate[0] = q2;
          to_l[0] = tsle_pkg::SITE_TWO; to_r[0] = tsle_pkg::SITE_EMPTY;
        end
        {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_EMPTY}: begin
          moves = 1; rate[0] = r_one;
          to_l[0] = tsle_pkg::SITE_EMPTY; to_r[0] = tsle_pkg::SITE_BOTH;
        end
        {tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_BOTH}: begin
          moves = 3;
          rate[0] = q4;  to_l[0] = tsle_pkg::SITE_BOTH; to_r[0] = tsle_pkg::SITE_EMPTY;
          rate[1] = q2e; to_l[1] = tsle_pkg::SITE_ONE;  to_r[1] = tsle_pkg::SITE_TWO;
          rate[2] = q2e; to_l[2] = tsle_pkg::SITE_TWO;  to_r[2] = tsle_pkg::SITE_ONE;
        end
        {tsle_pkg::SITE_ONE, tsle_pkg::SITE_TWO}: begin
          moves = 2;
          rate[0] = eps; to_l[0] = tsle_pkg::SITE_EMPTY; to_r[0] = tsle_pkg::SITE_BOTH;
          rate[1] = q2;  to_l[1] = tsle_pkg::SITE_TWO;   to_r[1] = tsle_pkg::SITE_ONE;
        end
        {tsle_pkg::SITE_TWO, tsle_pkg::SITE_ONE}: begin
          moves = 2;
          rate[0] = eps; to_l[0] = tsle_pkg::SITE_EMPTY; to_r[0] = tsle_pkg::SITE_BOTH;
          rate[1] = q2;  to_l[1] = tsle_pkg::SITE_ONE;   to_r[1] = tsle_pkg::SITE_TWO;
        end
        {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_ONE}: begin
          moves = 1; rate[0] = r_one;
          to_l[0] = tsle_pkg::SITE_ONE; to_r[0] = tsle_pkg::SITE_BOTH;
        end
        {tsle_pkg::SITE_ONE, tsle_pkg::SITE_BOTH}: begin
          moves = 1; rate[0] = q2;
          to_l[0] = tsle_pkg::SITE_BOTH; to_r[0] = tsle_pkg::SITE_ONE;
        end
        {tsle_pkg::SITE_BOTH, tsle_pkg::SITE_TWO}: begin
          moves = 1; rate[0] = r_one;
          to_l[0] = tsle_pkg::SITE_TWO; to_r[0] = tsle_pkg::SITE_BOTH;
        end
        {tsle_pkg::SITE_TWO, tsle_pkg::SITE_BOTH}: begin
          moves = 1; rate[0] = q2;
          to_l[0] = tsle_pkg::SITE_BOTH; to_r[0] = tsle_pkg::SITE_TWO;
        end
        default: moves = 0;
      endcase
      // first cumulative rate above the uniform number wins
      for (int k = 0; k < moves; k++) begin
        if (!res.fired) begin
          cum += rate[k];
          if (32'(req.uniform) < cum) begin
            res.fired = 1'b1;
            lhs = to_l[k];
            rhs = to_r[k];
          end
        end
      end
      site_model[pos]     = lhs;
      site_model[pos + 1] = rhs;
      res.new_left  = lhs;
      res.new_right = rhs;
    end else if (req.req_type == tsle_pkg::REQ_MEASURE) begin
      ones = 0;
      twos = 0;
      for (int i = LEFT_SITES; i < TOTAL_SITES; i++) begin
        ones += 32'(site_model[i][0]);
        twos += 32'(site_model[i][1]);
      end
      res.count_one = (ones > 32'(tsle_pkg::COUNT_MAX)) ?
                      tsle_pkg::COUNT_MAX : tsle_pkg::COUNT_W'(ones);
      res.count_two = (twos > 32'(tsle_pkg::COUNT_MAX)) ?
                      tsle_pkg::COUNT_MAX : tsle_pkg::COUNT_W'(twos);
    end else if (req.req_type == tsle_pkg::REQ_INIT) begin
      load_step_profile();
    end
    return res;
  endfunction

  function automatic void plan_row(input logic [tsle_pkg::REQ_W-1:0] kind, input int bond,
                                   input int uniform, input bit typed, input bit fired,
                                   input tsle_pkg::site_t left,
                                   input tsle_pkg::site_t right,
                                   input int ones, input int twos);
    directed_row_t row;
    row.req.req_type   = kind;
    row.req.bond       = tsle_pkg::BOND_W'(bond);
    row.req.uniform    = tsle_pkg::UNI_W'(uniform);
    row.typed          = typed;
    row.want.fired     = fired;
    row.want.new_left  = left;
    row.want.new_right = right;
    row.want.count_one = tsle_pkg::COUNT_W'(ones);
    row.want.count_two = tsle_pkg::COUNT_W'(twos);
    directed_plan.push_back(row);
  endfunction

  function automatic tsle_pkg::in_beat_t random_request();
    tsle_pkg::in_beat_t req;
    int unsigned        roll;
    roll        = $urandom_range(0, 99);
    req.bond    = tsle_pkg::BOND_W'($urandom_range(0, BOND_LAST));
    req.uniform = tsle_pkg::UNI_W'($urandom_range(0, 65535));
    if (roll < 80) begin
      req.req_type = tsle_pkg::REQ_UPDATE;
      req.bond     = tsle_pkg::BOND_W'($urandom_range(FRONT_LO, FRONT_HI));
    end else if (roll < 86) begin
      req.req_type = tsle_pkg::REQ_UPDATE;
    end else if (roll < 87) begin
      req.req_type = tsle_pkg::REQ_UPDATE;
      req.bond     = tsle_pkg::BOND_W'(BOND_LAST);
    end else if (roll < 94) begin
      req.req_type = tsle_pkg::REQ_MEASURE;
    end else if (roll < 97) begin
      req.req_type = tsle_pkg::REQ_INIT;
    end else begin
      req.req_type = REQ_UNUSED;
    end
    return req;
  endfunction

  // Offer one request; on acceptance queue its predicted (or typed) beat.
  task automatic offer_request(input tsle_pkg::in_beat_t req, input bit typed,
                               input tsle_pkg::out_beat_t typed_result);
    tsle_pkg::out_beat_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = exchange_predict(req);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic load_rates(input tsle_pkg::rates_t rates);
    cfg_we    <= 1'b1;
    cfg_index <= tsle_pkg::CFG_Q_SQUARED;
    cfg_wdata <= rates.q_squared;
    @(posedge clk);
    cfg_index <= tsle_pkg::CFG_Q_FOURTH;
    cfg_wdata <= rates.q_fourth;
    @(posedge clk);
    cfg_index <= tsle_pkg::CFG_Q_SQUARED_EPS;
    cfg_wdata <= rates.q_squared_eps;
    @(posedge clk);
    cfg_we      <= 1'b0;
    q2_model    = rates.q_squared;
    q4_model    = rates.q_fourth;
    q2eps_model = rates.q_squared_eps;
  endtask

  // receiver: random stall, plus one long counted hold on request
  initial begin
    int hold_count;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req <= 1'b0;
        out_stall   <= 1'b1;
        for (hold_count = 0; hold_count < RX_HOLD_CYCLES; hold_count++) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    tsle_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_data.fired);
          error_count++;
        end
        if (out_data.new_left !== want.new_left) begin
          $error("new_left: expected %0d, got %0d", want.new_left, out_data.new_left);
          error_count++;
        end
        if (out_data.new_right !== want.new_right) begin
          $error("new_right: expected %0d, got %0d", want.new_right, out_data.new_right);
          error_count++;
        end
        if (out_data.count_one !== want.count_one) begin
          $error("count_one: expected %0d, got %0d", want.count_one, out_data.count_one);
          error_count++;
        end
        if (out_data.count_two !== want.count_two) begin
          $error("count_two: expected %0d, got %0d", want.count_two, out_data.count_two);
          error_count++;
        end
      end
    end
  end

  initial begin
    tsle_pkg::rates_t    rates;
    tsle_pkg::out_beat_t no_result;
    no_result   = '0;
    q2_model    = tsle_pkg::Q_SQUARED_RST;
    q4_model    = tsle_pkg::Q_FOURTH_RST;
    q2eps_model = tsle_pkg::Q_SQUARED_EPS_RST;
    load_step_profile();

    // lattice after reset: sites left of the front hold both species
    plan_row(tsle_pkg::REQ_MEASURE, 0, 0, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, BOND_LAST, 12345, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(REQ_UNUSED, LEFT_SITES - 1, 65535, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, 0, 0, 1, 0,
             tsle_pkg::SITE_BOTH, tsle_pkg::SITE_BOTH, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, BOND_LAST - 1, 65535, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 0, 1, 1,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_BOTH, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 65535, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_BOTH, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 0, 1, 1,
             tsle_pkg::SITE_BOTH, tsle_pkg::SITE_EMPTY, 0, 0);
    // walk the rest of the exchange table around the front
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 65535, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 4096, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 50000, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 100, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 20000, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 60000, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 2, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 2, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 1, 50000, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 2, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES - 2, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_UPDATE, LEFT_SITES, 0, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_MEASURE, 2047, 65535, 0, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_INIT, 0, 0, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);
    plan_row(tsle_pkg::REQ_MEASURE, 0, 0, 1, 0,
             tsle_pkg::SITE_EMPTY, tsle_pkg::SITE_EMPTY, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 27;
    rx_idle_pct = 68;
    foreach (directed_plan[i]) begin
      offer_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      case (phase)
        0: begin
          rates.q_squared     = tsle_pkg::RATE_W'($urandom_range(0, tsle_pkg::RATE_ONE));
          rates.q_fourth      = tsle_pkg::RATE_W'($urandom_range(0, tsle_pkg::RATE_ONE));
          rates.q_squared_eps = tsle_pkg::RATE_W'($urandom_range(0, tsle_pkg::RATE_ONE));
        end
        1: rates = '0;
        2: rates = '{tsle_pkg::RATE_ONE, tsle_pkg::RATE_ONE, tsle_pkg::RATE_ONE};
        3: rates = '{RATE_FULL, RATE_FULL, RATE_FULL};
        4: begin
          rates.q_squared     = tsle_pkg::RATE_W'($urandom_range(0, RATE_FULL));
          rates.q_fourth      = tsle_pkg::RATE_W'($urandom_range(0, RATE_FULL));
          rates.q_squared_eps = tsle_pkg::RATE_W'($urandom_range(0, RATE_FULL));
        end
        default: rates = '{tsle_pkg::Q_SQUARED_RST, tsle_pkg::Q_FOURTH_RST,
                           tsle_pkg::Q_SQUARED_EPS_RST};
      endcase
      load_rates(rates);
      if (phase == 2) begin
        tx_idle_pct = 68;
        rx_idle_pct = 27;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the receiver so the block backs up onto its input
        rx_hold_req <= 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_request(random_request(), 1'b0, no_result);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("two_species_lattice_exchange_step_test: done, clean");
    end else begin
      $display("two_species_lattice_exchange_step_test: done, errors");
    end
    $finish;
  end

endmodule
